### src/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block.
// No dependencies; every other file but npcs_req_if imports this package.
package npcs_pkg;

  localparam logic [1:0] CMD_SEARCH  = 2'd0;
  localparam logic [1:0] CMD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_GAMMA   = 2'd2;

  localparam logic [1:0] GSEL_RED   = 2'd0;
  localparam logic [1:0] GSEL_GREEN = 2'd1;
  localparam logic [1:0] GSEL_BLUE  = 2'd2;

  localparam int unsigned WCOL_W = 17;
  localparam int unsigned COL_W  = 18;
  localparam int unsigned DIST_W = 35;
  localparam logic [17:0] ALPHA_WEIGHT = 18'd260100;
  localparam logic [8:0] ALPHA_SPAN = 9'd510;

  typedef struct packed {
    logic [1:0] gam_sel;
    logic       cap_pixel;
    logic       latch_r;
    logic       latch_g;
    logic       latch_b;
    logic       scan_start;
    logic       scan_issue;
    logic       out_load;
  } npcs_ctl_t;

  typedef struct packed {
    logic scan_last;
    logic size_zero;
    logic pipe_busy;
    logic out_free;
  } npcs_sts_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### src/npcs_req_if.sv
// Request and response channel interfaces of the palette search block.
// Depends on nothing; used by the top level.
interface npcs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] table_value;

  modport source (
    output valid, command, entry_index, red, green, blue, alpha, table_value,
    input ready
  );
  modport sink (
    input valid, command, entry_index, red, green, blue, alpha, table_value,
    output ready
  );
endinterface

interface npcs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] best_index;

  modport source (output valid, best_index, input ready);
  modport sink (input valid, best_index, output ready);
endinterface

### src/npcs_ctrl.sv
// Controller state machine for the palette search: sequences gamma lookups,
// the palette scan and the result hand-off. Depends on npcs_pkg.
module npcs_ctrl import npcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_command,
  output logic       req_ready,
  input  npcs_sts_t  sts,
  output npcs_ctl_t  ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GR    = 3'd1;
  localparam logic [2:0] S_GG    = 3'd2;
  localparam logic [2:0] S_GB    = 3'd3;
  localparam logic [2:0] S_GW    = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.gam_sel = GSEL_RED;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_command == CMD_SEARCH) begin
          ctl.cap_pixel = 1'b1;
          state_next = S_GR;
        end
      end
      S_GR: begin
        ctl.gam_sel = GSEL_RED;
        state_next = S_GG;
      end
      S_GG: begin
        ctl.gam_sel = GSEL_GREEN;
        ctl.latch_r = 1'b1;
        state_next = S_GB;
      end
      S_GB: begin
        ctl.gam_sel = GSEL_BLUE;
        ctl.latch_g = 1'b1;
        state_next = S_GW;
      end
      S_GW: begin
        ctl.latch_b = 1'b1;
        ctl.scan_start = 1'b1;
        state_next = sts.size_zero ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/npcs_dp.sv
// Datapath of the palette search: palette and gamma memories, size register,
// distance pipeline, best-match tracking and the result register. Depends on npcs_pkg.
module npcs_dp import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_accept,
  input  logic [1:0] req_command,
  input  logic [7:0] req_entry_index,
  input  logic [7:0] req_red,
  input  logic [7:0] req_green,
  input  logic [7:0] req_blue,
  input  logic [7:0] req_alpha,
  input  logic [7:0] req_table_value,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  input  npcs_ctl_t  ctl,
  output npcs_sts_t  sts,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] rsp_best_index
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  logic [31:0] pal_mem [PALETTE_DEPTH];
  logic [7:0]  gam_mem [256];
  logic [31:0] pal_q;
  logic [7:0]  gam_q;
  logic [7:0]  gam_addr;

  logic [8:0]  palette_size;
  logic [CW-1:0] size_sat;

  logic [7:0] px_red, px_green, px_blue, px_alpha;
  logic [7:0] gr, gg, gb;
  logic [WCOL_W-1:0] wcol;

  logic [AW-1:0] cnt;
  logic          v1, v2, v3;
  logic [AW-1:0] i1, i2, i3;
  logic [COL_W-1:0] col;
  logic [15:0]      da2;
  logic [DIST_W-1:0] prod_c, prod_a;
  logic [DIST_W-1:0] cand_d;
  logic [DIST_W-1:0] best_d;
  logic [AW-1:0]     best;
  logic              have;

  logic [7:0] dr, dg, db, da;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= 9'd256;
    end else if (cfg_we) begin
      palette_size <= cfg_wdata;
    end
  end

  assign size_sat = (palette_size > 9'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                        : CW'(palette_size);

  always_ff @(posedge clk) begin
    if (req_accept && req_command == CMD_PALETTE &&
        {1'b0, req_entry_index} < 9'(PALETTE_DEPTH)) begin
      pal_mem[req_entry_index[AW-1:0]] <= {req_alpha, req_blue, req_green, req_red};
    end
    pal_q <= pal_mem[cnt];
  end

  always_comb begin
    unique case (ctl.gam_sel)
      GSEL_RED:   gam_addr = px_red;
      GSEL_GREEN: gam_addr = px_green;
      GSEL_BLUE:  gam_addr = px_blue;
      default:    gam_addr = px_red;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_accept && req_command == CMD_GAMMA) begin
      gam_mem[req_entry_index] <= req_table_value;
    end
    gam_q <= gam_mem[gam_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_pixel) begin
      px_red   <= req_red;
      px_green <= req_green;
      px_blue  <= req_blue;
      px_alpha <= req_alpha;
    end
    if (ctl.latch_r) gr <= gam_q;
    if (ctl.latch_g) gg <= gam_q;
    if (ctl.latch_b) gb <= gam_q;
    wcol <= WCOL_W'({9'd0, px_alpha} * (ALPHA_SPAN - {1'b0, px_alpha}));
  end

  assign dr = abs_diff(pal_q[7:0],   gr);
  assign dg = abs_diff(pal_q[15:8],  gg);
  assign db = abs_diff(pal_q[23:16], gb);
  assign da = abs_diff(pal_q[31:24], px_alpha);
  assign cand_d = prod_c + prod_a;

  always_ff @(posedge clk) begin
    i1 <= cnt;
    i2 <= i1;
    i3 <= i2;
    col <= COL_W'({8'd0, dr} * {8'd0, dr}) + COL_W'({8'd0, dg} * {8'd0, dg}) +
           COL_W'({8'd0, db} * {8'd0, db});
    da2 <= {8'd0, da} * {8'd0, da};
    prod_c <= DIST_W'(wcol * col);
    prod_a <= DIST_W'(ALPHA_WEIGHT * da2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      have <= 1'b0;
      best <= '0;
    end else begin
      v1 <= ctl.scan_issue;
      v2 <= v1;
      v3 <= v2;
      if (ctl.scan_start) begin
        cnt  <= '0;
        have <= 1'b0;
        best <= '0;
      end else begin
        if (ctl.scan_issue) begin
          cnt <= cnt + AW'(1);
        end
        if (v3 && (!have || cand_d < best_d)) begin
          have   <= 1'b1;
          best   <= i3;
          best_d <= cand_d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp_best_index <= 8'(best);
    end
  end

  assign sts.scan_last = (CW'(cnt) == size_sat - CW'(1));
  assign sts.size_zero = (size_sat == '0);
  assign sts.pipe_busy = v1 | v2 | v3;
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

### src/nearest_palette_color_search_top.sv
// Top level of the nearest palette color search block.
// Depends on npcs_pkg, npcs_req_if, npcs_rsp_if, npcs_ctrl and npcs_dp.
//
// Requests carry one of three commands. Palette and gamma writes give no
// response. A search runs the red, green and blue gamma lookups through the
// single read port of the gamma memory, reads one palette entry per cycle
// from the palette memory, and feeds a three-stage distance pipeline that
// drains at the end. A palette_size of zero returns index 0 without a scan.
// The result waits in an output register; one search runs at a time, and a
// new request is taken once the previous search has handed its result to
// that register. The user must write palette_size only while no search is
// in progress; the block itself does not enforce this.
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  npcs_req_if.sink   req,
  npcs_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);

  npcs_ctl_t ctl;
  npcs_sts_t sts;
  logic      req_accept;

  assign req_accept = req.valid && req.ready;

  npcs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .sts         (sts),
    .ctl         (ctl)
  );

  npcs_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_accept      (req_accept),
    .req_command     (req.command),
    .req_entry_index (req.entry_index),
    .req_red         (req.red),
    .req_green       (req.green),
    .req_blue        (req.blue),
    .req_alpha       (req.alpha),
    .req_table_value (req.table_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .ctl             (ctl),
    .sts             (sts),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_best_index  (rsp.best_index)
  );

  // No request is taken while distances are still in flight.
  assert property (@(posedge clk) disable iff (rst) sts.pipe_busy |-> !req.ready)
    else $error("request accepted during palette scan");

  // An accepted search request occupies the block on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_accept && req.command == CMD_SEARCH) |=> !req.ready)
    else $error("search request did not start a search");

  // The scan stops issuing reads after the last entry.
  assert property (@(posedge clk) disable iff (rst)
    (ctl.scan_issue && sts.scan_last) |=> !ctl.scan_issue)
    else $error("palette scan ran past its last entry");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for nearest_palette_color_search_top: loads gamma and palette
// tables, runs directed and random searches, and checks every best_index response.
// Depends on npcs_pkg, npcs_req_if, npcs_rsp_if and the top level of the block.
module tb;
  import npcs_pkg::*;

  localparam int PAL_DEPTH = 256;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] table_value;
  } npcs_op_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct {
    bit         set_size;
    logic [8:0] size;
    npcs_op_t   op;
    bit         typed;
    logic [7:0] want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic req_typed = 1'b0;
  logic [7:0] req_want = '0;
  bit steady = 1'b0;

  rgba_t palette_lut [PAL_DEPTH];
  logic [7:0] gamma_lut [256];
  logic [8:0] scan_size = 9'd256;
  logic [7:0] best_index_q [$];
  logic [7:0] want_index;
  int mismatches = 0;
  int results_seen = 0;
  plan_row_t directed_plan [$];

  npcs_req_if req ();
  npcs_rsp_if rsp ();

  nearest_palette_color_search_top #(.PALETTE_DEPTH(PAL_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic npcs_op_t mk_op(input logic [1:0] cmd, input logic [7:0] idx, r, g, b,
                                     a, tv);
    mk_op = '{command: cmd, entry_index: idx, red: r, green: g, blue: b, alpha: a,
              table_value: tv};
  endfunction

  function automatic plan_row_t cfg_row(input logic [8:0] size);
    cfg_row = '{set_size: 1'b1, size: size, op: '0, typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t op_row(input logic [1:0] cmd, input logic [7:0] idx, r, g,
                                       b, a, tv);
    op_row = '{set_size: 1'b0, size: '0, op: mk_op(cmd, idx, r, g, b, a, tv), typed: 1'b0,
               want: '0};
  endfunction

  function automatic plan_row_t chk_row(input logic [7:0] r, g, b, a, want);
    chk_row = '{set_size: 1'b0, size: '0, op: mk_op(CMD_SEARCH, 8'd0, r, g, b, a, 8'd0),
                typed: 1'b1, want: want};
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    nudge = 8'(t);
  endfunction

  function automatic logic [7:0] nearest_entry(input logic [7:0] r, g, b, a);
    longint unsigned cand_dist, best_dist;
    int n, dr, dg, db, da, wa;
    logic [7:0] best, gr, gg, gb;
    gr = gamma_lut[r];
    gg = gamma_lut[g];
    gb = gamma_lut[b];
    wa = int'(a) * (510 - int'(a));
    n = (int'(scan_size) > PAL_DEPTH) ? PAL_DEPTH : int'(scan_size);
    best = '0;
    best_dist = '1;
    for (int i = 0; i < n; i++) begin
      dr = int'(palette_lut[i].r) - int'(gr);
      dg = int'(palette_lut[i].g) - int'(gg);
      db = int'(palette_lut[i].b) - int'(gb);
      da = int'(palette_lut[i].a) - int'(a);
      cand_dist = 64'(wa) * 64'(dr * dr + dg * dg + db * db) + 64'd260100 * 64'(da * da);
      if (i == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best = 8'(i);
      end
    end
    nearest_entry = best;
  endfunction

  task automatic offer(input npcs_op_t o, input bit typed, input logic [7:0] want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 16) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.command <= o.command;
    req.entry_index <= o.entry_index;
    req.red <= o.red;
    req.green <= o.green;
    req.blue <= o.blue;
    req.alpha <= o.alpha;
    req.table_value <= o.table_value;
    req_typed <= typed;
    req_want <= want;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic set_size(input logic [8:0] size);
    go_quiet();
    while (best_index_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    scan_size = size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] size, input int count);
    npcs_op_t o;
    rgba_t e;
    int n, pick;
    set_size(size);
    n = (int'(size) > PAL_DEPTH) ? PAL_DEPTH : int'(size);
    repeat (count) begin
      pick = int'($urandom_range(99));
      o = mk_op(CMD_SEARCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
      if (pick < 45) begin
        if (n > 0 && $urandom_range(9) < 4) begin
          e = palette_lut[$urandom_range(n - 1)];
          o.red = nudge(e.r);
          o.green = nudge(e.g);
          o.blue = nudge(e.b);
          o.alpha = nudge(e.a);
        end
      end else if (pick < 70) begin
        o.command = CMD_PALETTE;
        if ($urandom_range(3) == 0) begin
          e = palette_lut[8'($urandom)];
          o.red = e.r;
          o.green = e.g;
          o.blue = e.b;
          o.alpha = e.a;
        end
      end else if (pick < 90) begin
        o.command = CMD_GAMMA;
        if ($urandom_range(1) == 1) o.table_value = o.entry_index;
      end else begin
        o.command = CMD_UNUSED;
      end
      if ($urandom_range(7) == 0) o.alpha = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      offer(o, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      case (req.command)
        CMD_SEARCH: begin
          best_index_q.push_back(req_typed ? req_want :
                                 nearest_entry(req.red, req.green, req.blue, req.alpha));
        end
        CMD_PALETTE: begin
          if (int'(req.entry_index) < PAL_DEPTH)
            palette_lut[req.entry_index] = '{r: req.red, g: req.green, b: req.blue,
                                             a: req.alpha};
        end
        CMD_GAMMA: gamma_lut[req.entry_index] = req.table_value;
        default: ;
      endcase
    end
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (best_index_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected best_index %0d with no search pending.", rsp.best_index);
      end else begin
        want_index = best_index_q.pop_front();
        if (rsp.best_index !== want_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("best_index mismatch: expected %0d, got %0d.", want_index,
                     rsp.best_index);
        end
      end
    end
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 120) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp.ready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [8:0] sizes [10];
    req.valid = 1'b0;
    req.command = CMD_SEARCH;
    req.entry_index = '0;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    req.alpha = '0;
    req.table_value = '0;
    directed_plan = '{
      cfg_row(9'd4),
      op_row(CMD_GAMMA, 0, 0, 0, 0, 0, 0),
      op_row(CMD_GAMMA, 255, 0, 0, 0, 0, 255),
      op_row(CMD_PALETTE, 0, 0, 0, 0, 0, 0),
      op_row(CMD_PALETTE, 1, 255, 255, 255, 255, 0),
      op_row(CMD_PALETTE, 2, 255, 255, 255, 0, 0),
      op_row(CMD_PALETTE, 3, 0, 0, 0, 255, 0),
      chk_row(0, 0, 0, 0, 0),
      chk_row(255, 255, 255, 255, 1),
      chk_row(255, 255, 255, 0, 0),
      chk_row(0, 0, 0, 255, 3),
      op_row(CMD_SEARCH, 0, 255, 0, 255, 128, 0),
      op_row(CMD_UNUSED, 0, 255, 255, 255, 255, 255),
      chk_row(0, 0, 0, 255, 3),
      op_row(CMD_GAMMA, 0, 0, 0, 0, 0, 255),
      chk_row(0, 0, 0, 255, 1),
      op_row(CMD_GAMMA, 0, 0, 0, 0, 0, 0),
      cfg_row(9'd0),
      chk_row(255, 0, 255, 128, 0),
      cfg_row(9'd1),
      chk_row(255, 255, 255, 255, 0),
      op_row(CMD_PALETTE, 255, 1, 2, 3, 4, 0)
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].set_size) set_size(directed_plan[k].size);
      else offer(directed_plan[k].op, directed_plan[k].typed, directed_plan[k].want);
    end

    // Fill both tables in order; searches only touch gamma entries written so far.
    for (int i = 0; i < 256; i++) begin
      offer(mk_op(CMD_GAMMA, 8'(i), 8'd0, 8'd0, 8'd0, 8'd0,
                  ($urandom_range(3) == 0) ? 8'($urandom) : 8'(i)), 1'b0, '0);
      offer(mk_op(CMD_PALETTE, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom)), 1'b0, '0);
      if ($urandom_range(2) == 0)
        offer(mk_op(CMD_SEARCH, 8'($urandom), 8'($urandom_range(i)), 8'($urandom_range(i)),
                    8'($urandom_range(i)), 8'($urandom), 8'($urandom)), 1'b0, '0);
    end

    sizes = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd1, 9'd257, 9'd16, 9'd255,
              9'($urandom_range(64, 1)), 9'($urandom_range(511))};
    for (int p = 0; p < 10; p++) begin
      steady = (p == 6);
      run_phase(sizes[p], 133);
    end
    steady = 1'b0;

    go_quiet();
    while (best_index_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
